/* rtl/cpid_pkg.sv */
// Shared types and constants for the clamped PID controller.
// No dependencies; imported by every module of the block.
package cpid_pkg;

  localparam int ERR_CLAMP_HI_DEF  = 32767;
  localparam int ERR_CLAMP_LO_DEF  = -32768;
  localparam int DIFF_CLAMP_HI_DEF = 32767;
  localparam int DIFF_CLAMP_LO_DEF = -32768;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = 3'd6;

  localparam logic signed [15:0] GAIN_PROP_RST   = 16'sd256;
  localparam logic signed [15:0] GAIN_INTEG_RST  = 16'sd0;
  localparam logic signed [15:0] GAIN_DERIV_RST  = 16'sd0;
  localparam logic signed [23:0] INTEG_UPPER_RST = 24'sh7fffff;
  localparam logic signed [23:0] INTEG_LOWER_RST = 24'sh800000;
  localparam logic signed [15:0] DRIVE_UPPER_RST = 16'sh7fff;
  localparam logic signed [15:0] DRIVE_LOWER_RST = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
    logic signed [23:0] integ_upper;
    logic signed [23:0] integ_lower;
    logic signed [15:0] drive_upper;
    logic signed [15:0] drive_lower;
  } cpid_cfg_t;

  typedef struct packed {
    logic               clr;
    logic signed [15:0] err;
    logic signed [23:0] integ;
    logic signed [15:0] deriv;
  } cpid_terms_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } cpid_pipe_ctl_t;

endpackage

/* rtl/cpid_state.sv */
// Error, clamped integral and derivative stage; owns integral and last-error state.
// Depends on cpid_pkg.
module cpid_state
  import cpid_pkg::*;
#(
  parameter int ERR_CLAMP_HI  = ERR_CLAMP_HI_DEF,
  parameter int ERR_CLAMP_LO  = ERR_CLAMP_LO_DEF,
  parameter int DIFF_CLAMP_HI = DIFF_CLAMP_HI_DEF,
  parameter int DIFF_CLAMP_LO = DIFF_CLAMP_LO_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cpid_pipe_ctl_t     ctl,
  input  cpid_cfg_t          cfg,
  input  logic               op,
  input  logic signed [15:0] setpoint,
  input  logic signed [15:0] measured,
  output cpid_terms_t        terms
);

  localparam logic signed [16:0] ERR_HI_W  = 17'(ERR_CLAMP_HI);
  localparam logic signed [16:0] ERR_LO_W  = 17'(ERR_CLAMP_LO);
  localparam logic signed [16:0] DIFF_HI_W = 17'(DIFF_CLAMP_HI);
  localparam logic signed [16:0] DIFF_LO_W = 17'(DIFF_CLAMP_LO);

  logic signed [23:0] integ_acc_r, integ_acc_nxt;
  logic signed [15:0] prev_err_r, prev_err_nxt;
  cpid_terms_t        terms_r, terms_nxt;

  logic signed [16:0] diff;
  logic signed [15:0] err;
  logic signed [24:0] isum;
  logic signed [24:0] iup;
  logic signed [24:0] ilo;
  logic signed [23:0] integ;
  logic signed [16:0] dd;
  logic signed [15:0] deriv;

  always_comb begin
    diff = $signed({setpoint[15], setpoint}) - $signed({measured[15], measured});
    if (diff > ERR_HI_W) begin
      err = ERR_HI_W[15:0];
    end else if (diff < ERR_LO_W) begin
      err = ERR_LO_W[15:0];
    end else begin
      err = diff[15:0];
    end

    isum = $signed({integ_acc_r[23], integ_acc_r}) + $signed({{9{err[15]}}, err});
    iup  = $signed({cfg.integ_upper[23], cfg.integ_upper});
    ilo  = $signed({cfg.integ_lower[23], cfg.integ_lower});
    if (isum > iup) begin
      integ = cfg.integ_upper;
    end else if (isum < ilo) begin
      integ = cfg.integ_lower;
    end else begin
      integ = isum[23:0];
    end

    dd = $signed({err[15], err}) - $signed({prev_err_r[15], prev_err_r});
    if (dd > DIFF_HI_W) begin
      deriv = DIFF_HI_W[15:0];
    end else if (dd < DIFF_LO_W) begin
      deriv = DIFF_LO_W[15:0];
    end else begin
      deriv = dd[15:0];
    end

    if (op) begin
      terms_nxt.clr   = 1'b1;
      terms_nxt.err   = '0;
      terms_nxt.integ = '0;
      terms_nxt.deriv = '0;
      integ_acc_nxt   = '0;
      prev_err_nxt    = '0;
    end else begin
      terms_nxt.clr   = 1'b0;
      terms_nxt.err   = err;
      terms_nxt.integ = integ;
      terms_nxt.deriv = deriv;
      integ_acc_nxt   = integ;
      prev_err_nxt    = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r <= '0;
      prev_err_r  <= '0;
    end else if (ctl.load1) begin
      integ_acc_r <= integ_acc_nxt;
      prev_err_r  <= prev_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

/* rtl/cpid_mac.sv */
// Gain products, sum, floor shift and drive clamp; holds the result register.
// Depends on cpid_pkg.
module cpid_mac
  import cpid_pkg::*;
(
  input  logic               clk,
  input  cpid_pipe_ctl_t     ctl,
  input  cpid_cfg_t          cfg,
  input  cpid_terms_t        terms,
  output logic signed [15:0] drive,
  output logic signed [15:0] err_out,
  output logic signed [23:0] integ_out,
  output logic signed [15:0] deriv_out
);

  logic signed [31:0] p_prop_r;
  logic signed [39:0] p_integ_r;
  logic signed [31:0] p_deriv_r;
  cpid_terms_t        terms2_r;

  logic signed [15:0] drive_r, drive_nxt;
  logic signed [15:0] err_r;
  logic signed [23:0] integ_r;
  logic signed [15:0] deriv_r;

  logic signed [41:0] sum;
  logic signed [33:0] shr;
  logic signed [33:0] dup;
  logic signed [33:0] dlo;

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      p_prop_r  <= cfg.gain_prop * terms.err;
      p_integ_r <= cfg.gain_integ * terms.integ;
      p_deriv_r <= cfg.gain_deriv * terms.deriv;
      terms2_r  <= terms;
    end
  end

  always_comb begin
    sum = $signed({{10{p_prop_r[31]}}, p_prop_r})
        + $signed({{2{p_integ_r[39]}}, p_integ_r})
        + $signed({{10{p_deriv_r[31]}}, p_deriv_r});
    shr = sum[41:8];
    dup = $signed({{18{cfg.drive_upper[15]}}, cfg.drive_upper});
    dlo = $signed({{18{cfg.drive_lower[15]}}, cfg.drive_lower});
    if (terms2_r.clr) begin
      drive_nxt = '0;
    end else if (shr > dup) begin
      drive_nxt = cfg.drive_upper;
    end else if (shr < dlo) begin
      drive_nxt = cfg.drive_lower;
    end else begin
      drive_nxt = shr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      drive_r <= drive_nxt;
      err_r   <= terms2_r.err;
      integ_r <= terms2_r.integ;
      deriv_r <= terms2_r.deriv;
    end
  end

  assign drive     = drive_r;
  assign err_out   = err_r;
  assign integ_out = integ_r;
  assign deriv_out = deriv_r;

endmodule

/* rtl/clamped_pid_controller_top.sv */
// Top level of the clamped PID controller: ports, config registers, pipeline control.
// Depends on cpid_pkg, cpid_state and cpid_mac.
//
//   channel | ports                                   | direction
//   in      | in_valid/in_ready, in_op, in_setpoint,  | input transaction
//           | in_measured                             |
//   out     | out_valid/out_ready, out_drive,         | result transaction
//           | out_err_out, out_integ_out, out_deriv_out |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | register write, always ready
//
// One transaction per cycle sustained while out_ready holds; a taken input moves
// through the input reg, state stage, product stage and result reg to out_valid.
// The integral/last-error update registers as the state stage loads, so issue never waits.
// Each stage advances when the next one is empty or moving, so bubbles fill under
// an output stall. Synchronous reset empties the pipe, zeroes state and loads
// register defaults.
module clamped_pid_controller_top
  import cpid_pkg::*;
#(
  parameter int ERR_CLAMP_HI  = ERR_CLAMP_HI_DEF,
  parameter int ERR_CLAMP_LO  = ERR_CLAMP_LO_DEF,
  parameter int DIFF_CLAMP_HI = DIFF_CLAMP_HI_DEF,
  parameter int DIFF_CLAMP_LO = DIFF_CLAMP_LO_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic signed [15:0]    in_setpoint,
  input  logic signed [15:0]    in_measured,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_drive,
  output logic signed [15:0]    out_err_out,
  output logic signed [23:0]    out_integ_out,
  output logic signed [15:0]    out_deriv_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cpid_cfg_t      cfg_r;
  cpid_pipe_ctl_t ctl;
  cpid_terms_t    terms;

  logic               v0_r, v1_r, v2_r, v3_r;
  logic               rdy0, rdy1, rdy2, rdy3;
  logic               op_r;
  logic signed [15:0] sp_r;
  logic signed [15:0] pv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop   <= GAIN_PROP_RST;
      cfg_r.gain_integ  <= GAIN_INTEG_RST;
      cfg_r.gain_deriv  <= GAIN_DERIV_RST;
      cfg_r.integ_upper <= INTEG_UPPER_RST;
      cfg_r.integ_lower <= INTEG_LOWER_RST;
      cfg_r.drive_upper <= DRIVE_UPPER_RST;
      cfg_r.drive_lower <= DRIVE_LOWER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_PROP:   cfg_r.gain_prop   <= $signed(cfg_data[15:0]);
        REG_GAIN_INTEG:  cfg_r.gain_integ  <= $signed(cfg_data[15:0]);
        REG_GAIN_DERIV:  cfg_r.gain_deriv  <= $signed(cfg_data[15:0]);
        REG_INTEG_UPPER: cfg_r.integ_upper <= $signed(cfg_data[23:0]);
        REG_INTEG_LOWER: cfg_r.integ_lower <= $signed(cfg_data[23:0]);
        REG_DRIVE_UPPER: cfg_r.drive_upper <= $signed(cfg_data[15:0]);
        REG_DRIVE_LOWER: cfg_r.drive_lower <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  assign ctl.load1 = v0_r && rdy1;
  assign ctl.load2 = v1_r && rdy2;
  assign ctl.load3 = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      op_r <= in_op;
      sp_r <= in_setpoint;
      pv_r <= in_measured;
    end
  end

  cpid_state #(
    .ERR_CLAMP_HI  (ERR_CLAMP_HI),
    .ERR_CLAMP_LO  (ERR_CLAMP_LO),
    .DIFF_CLAMP_HI (DIFF_CLAMP_HI),
    .DIFF_CLAMP_LO (DIFF_CLAMP_LO)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cfg      (cfg_r),
    .op       (op_r),
    .setpoint (sp_r),
    .measured (pv_r),
    .terms    (terms)
  );

  cpid_mac u_mac (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .terms     (terms),
    .drive     (out_drive),
    .err_out   (out_err_out),
    .integ_out (out_integ_out),
    .deriv_out (out_deriv_out)
  );

  assign out_valid = v3_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !v0_r)
    else $error("pipeline not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && v0_r) |-> ctl.load1)
    else $error("input register overwritten before it moved on");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && terms.clr) |-> (terms.err == 16'sd0 && terms.integ == 24'sd0
                             && terms.deriv == 16'sd0))
    else $error("clear transaction carries nonzero terms");
`endif

endmodule
